[src/tmtw_pkg.sv]
// Shared types, constants and address helper for the text-mode terminal writer.
// No dependencies; imported by text_mode_terminal_writer.
package tmtw_pkg;

    localparam int SCREEN_COLUMNS = 80;
    localparam int SCREEN_ROWS    = 25;
    localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;
    localparam int MOVE_COUNT     = CELL_COUNT - SCREEN_COLUMNS;

    localparam int CELL_W   = 16;
    localparam int ADDR_W   = $clog2(CELL_COUNT);
    localparam int COL_W    = $clog2(SCREEN_COLUMNS);
    localparam int ROW_W    = $clog2(SCREEN_ROWS);
    localparam int COL_IN_W = 7;
    localparam int ROW_IN_W = 6;

    localparam int CURSOR_ROW_W = 5;
    localparam int CURSOR_COL_W = 7;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CELL_W-1:0] cell_t;

    localparam logic [1:0] CMD_PUT_CURSOR = 2'd0;
    localparam logic [1:0] CMD_PUT_AT     = 2'd1;
    localparam logic [1:0] CMD_READ       = 2'd2;
    localparam logic [1:0] CMD_NONE       = 2'd3;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam cell_t      BLANK_CELL   = 16'h0720;
    localparam cell_t      CLEAR_CELL   = 16'h0000;
    localparam logic [7:0] COLOR_RESET  = 8'h07;

    function automatic addr_t cell_addr(logic [ROW_IN_W-1:0] r, logic [COL_IN_W-1:0] c);
        cell_addr = addr_t'(addr_t'(r) * addr_t'(SCREEN_COLUMNS)) + addr_t'(c);
    endfunction

endpackage

[src/tmtw_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tmtw_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[src/text_mode_terminal_writer.sv]
// Text-mode terminal writer: screen store in one RAM, cursor and command sequencer.
// Depends on tmtw_pkg and tmtw_ram.
// A cursor put that leaves the bottom row (wrap or newline) scrolls the screen: one cell
// moved per cycle over the single RAM write port, then the bottom row is cleared.
// One transfer at a time: s_tready stays low until its result is loaded into the output
// register.
// Reset: a clearing pass writes 0x0720 to all CELL_COUNT (2000) cells, one per
// cycle; s_tready stays low until it ends. Config writes are taken at any time.
module text_mode_terminal_writer
    import tmtw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // char_code[7:0], entry_color[15:8], column[22:16], row[28:23], zero fill
    input  logic [31:0] s_tdata,
    // cmd[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // cell_value[15:0], cursor_row[20:16], cursor_column[27:21],
    // position_error[28], zero fill
    output logic [31:0] m_tdata
);

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_SCROLL = 3'd3;
    localparam logic [2:0] S_CLEAR  = 3'd4;
    localparam logic [2:0] S_EMIT   = 3'd5;

    logic [2:0]       state_reg, state_next;
    addr_t            cnt_reg, cnt_next;
    logic [ROW_W-1:0] cur_row_reg, cur_row_next;
    logic [COL_W-1:0] cur_col_reg, cur_col_next;
    logic [7:0]       text_color_reg;
    cell_t            cell_reg, cell_next;
    logic             err_reg, err_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [31:0]      m_tdata_reg, m_tdata_next;

    logic             ram_we, ram_re;
    addr_t            ram_waddr, ram_raddr;
    cell_t            ram_wdata, ram_rdata;

    logic [7:0]       in_char;
    logic [7:0]       in_color;
    logic [6:0]       in_col;
    logic [5:0]       in_row;
    logic [1:0]       in_cmd;
    logic             in_inside;
    logic             accept;
    addr_t            in_addr;
    addr_t            cur_addr;
    logic             col_last;
    logic             row_last;

    assign in_char   = s_tdata[7:0];
    assign in_color  = s_tdata[15:8];
    assign in_col    = s_tdata[22:16];
    assign in_row    = s_tdata[28:23];
    assign in_cmd    = s_tuser;
    assign in_inside = ({1'b0, in_col} < 8'(SCREEN_COLUMNS))
                    && ({1'b0, in_row} < 7'(SCREEN_ROWS));
    assign in_addr   = cell_addr(in_row, in_col);
    assign cur_addr  = cell_addr(ROW_IN_W'(cur_row_reg), COL_IN_W'(cur_col_reg));
    assign col_last  = (cur_col_reg == COL_W'(SCREEN_COLUMNS - 1));
    assign row_last  = (cur_row_reg == ROW_W'(SCREEN_ROWS - 1));

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    tmtw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_comb
    begin
        ram_we     = 1'b0;
        ram_waddr  = cnt_reg;
        ram_wdata  = BLANK_CELL;
        ram_re     = 1'b0;
        ram_raddr  = in_addr;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        cell_next  = cell_reg;
        err_next   = err_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;

        unique case (state_reg)
            S_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                ram_wdata = BLANK_CELL;
                if (cnt_reg == addr_t'(CELL_COUNT - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cell_next  = CLEAR_CELL;
                    err_next   = 1'b0;
                    state_next = S_EMIT;
                    unique case (in_cmd)
                        CMD_PUT_CURSOR:
                        begin
                            if (in_char != NEWLINE_CODE)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = cur_addr;
                                ram_wdata = {text_color_reg, in_char};
                            end
                            if (in_char == NEWLINE_CODE || col_last)
                            begin
                                cur_col_next = '0;
                                if (row_last)
                                begin
                                    cnt_next   = '0;
                                    state_next = S_SCROLL;
                                end
                                else
                                begin
                                    cur_row_next = cur_row_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                cur_col_next = cur_col_reg + 1'b1;
                            end
                        end
                        CMD_PUT_AT:
                        begin
                            err_next = !in_inside;
                            if (in_inside)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = in_addr;
                                ram_wdata = {in_color, in_char};
                            end
                        end
                        CMD_READ:
                        begin
                            err_next = !in_inside;
                            if (in_inside)
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = in_addr;
                                state_next = S_READ;
                            end
                        end
                        CMD_NONE:
                        begin
                            err_next = 1'b0;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                cell_next  = ram_rdata;
                state_next = S_EMIT;
            end
            S_SCROLL:
            begin
                ram_re    = (cnt_reg < addr_t'(MOVE_COUNT));
                ram_raddr = cnt_reg + addr_t'(SCREEN_COLUMNS);
                ram_we    = (cnt_reg != '0);
                ram_waddr = cnt_reg - 1'b1;
                ram_wdata = ram_rdata;
                if (cnt_reg == addr_t'(MOVE_COUNT))
                begin
                    state_next = S_CLEAR;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                ram_wdata = CLEAR_CELL;
                if (cnt_reg == addr_t'(CELL_COUNT - 1))
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000, err_reg,
                                     CURSOR_COL_W'(cur_col_reg),
                                     CURSOR_ROW_W'(cur_row_reg),
                                     cell_reg};
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            cnt_reg        <= '0;
            cur_row_reg    <= '0;
            cur_col_reg    <= '0;
            text_color_reg <= COLOR_RESET;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            cur_row_reg  <= cur_row_next;
            cur_col_reg  <= cur_col_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we)
            begin
                text_color_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg    <= cell_next;
        err_reg     <= err_next;
        m_tdata_reg <= m_tdata_next;
    end

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_col_reg < COL_W'(SCREEN_COLUMNS - 1) || col_last)
        else $error("cursor column off screen");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_row_reg < ROW_W'(SCREEN_ROWS - 1) || row_last)
        else $error("cursor row off screen");

    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INIT || state_reg == S_SCROLL || state_reg == S_CLEAR)
        |-> !s_tready)
        else $error("input taken during a RAM sweep");

    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg) == S_EMIT)
        else $error("result raised outside the emit step");

    a_scroll_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCROLL |-> cnt_reg <= addr_t'(MOVE_COUNT))
        else $error("scroll counter overran");

endmodule
